### rtl/core/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and codes for the indexed shift array core.
// ----------------------------------------------------------------------------
`default_nettype none

package isa_pkg;

  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int FOUND_W = 6;
  localparam int FILL_W  = 7;
  localparam int STAT_W  = 2;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_UPDATE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } state_t;

  // per-transaction command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic upd;
    logic srch;
    logic rd;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/isa_cell.sv
// ----------------------------------------------------------------------------
// isa_cell
// One array entry: shifts with its neighbors, takes writes, flags a match or a read.
// ----------------------------------------------------------------------------
`default_nettype none

module isa_cell import isa_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  wire logic              clk,
  input  wire cmd_t              cmd,
  input  wire logic [PW-1:0]     pos,
  input  wire logic [PW-1:0]     count,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [DATA_W-1:0] left,
  input  wire logic [DATA_W-1:0] right,
  output logic      [DATA_W-1:0] entry,
  output logic                   hit
);

  logic [PW-1:0] my_idx;
  logic          above;
  logic          at;

  assign my_idx = PW'(IDX);
  assign above  = my_idx > pos;
  assign at     = my_idx == pos;

  always_ff @(posedge clk) begin
    if (cmd.ins && above) begin
      entry <= left;
    end else if ((cmd.ins || cmd.upd) && at) begin
      entry <= value;
    end else if (cmd.del && (above || at)) begin
      entry <= right;
    end
  end

  assign hit = (cmd.srch && (my_idx < count) && (entry == value)) || (cmd.rd && at);

endmodule

`default_nettype wire

### rtl/core/isa_find_tree.sv
// ----------------------------------------------------------------------------
// isa_find_tree
// Registered priority tree: lowest flagged cell with its index and data.
// ----------------------------------------------------------------------------
`default_nettype none

module isa_find_tree import isa_pkg::*; #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  wire logic              clk,
  input  wire logic [N-1:0]      leaf_hit,
  input  wire logic [DATA_W-1:0] leaf_data [N],
  output logic                   root_hit,
  output logic      [IW-1:0]     root_idx,
  output logic      [DATA_W-1:0] root_data
);

  localparam int P = 1 << IW;

  logic              node_hit  [2*P-1];
  logic [IW-1:0]     node_idx  [2*P-1];
  logic [DATA_W-1:0] node_data [2*P-1];
  logic              sum_hit   [P-1];
  logic [IW-1:0]     sum_idx   [P-1];
  logic [DATA_W-1:0] sum_data  [P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign node_hit[P-1+j]  = leaf_hit[j];
      assign node_data[P-1+j] = leaf_data[j];
    end else begin : g_pad
      assign node_hit[P-1+j]  = 1'b0;
      assign node_data[P-1+j] = '0;
    end
    assign node_idx[P-1+j] = IW'(j);
  end

  for (genvar n = 0; n < P-1; n++) begin : g_node
    assign node_hit[n]  = sum_hit[n];
    assign node_idx[n]  = sum_idx[n];
    assign node_data[n] = sum_data[n];
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < P-1; n++) begin
      sum_hit[n] <= node_hit[2*n+1] || node_hit[2*n+2];
      if (node_hit[2*n+1]) begin
        sum_idx[n]  <= node_idx[2*n+1];
        sum_data[n] <= node_data[2*n+1];
      end else begin
        sum_idx[n]  <= node_idx[2*n+2];
        sum_data[n] <= node_data[2*n+2];
      end
    end
  end

  assign root_hit  = node_hit[0];
  assign root_idx  = node_idx[0];
  assign root_data = node_data[0];

endmodule

`default_nettype wire

### rtl/core/indexed_shift_array_core.sv
// ----------------------------------------------------------------------------
// indexed_shift_array_core
// Ordered array of signed words with insert, delete, search, update and read.
// ----------------------------------------------------------------------------
// results: insert, delete, update and refused requests raise done at the edge after
//   the one that takes start; search and read first wait in S_WAIT while the
//   registered priority tree over the cell row resolves
// flow: busy drops as done rises, so the next start is taken at the edge ending
//   the result; a new request is never taken while one is still in flight
// reset: rst clears the internal fill count and control; entry contents and the registered result outputs stay unknown
`default_nettype none

module indexed_shift_array_core import isa_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [2:0]        op,
  input  wire logic        [POS_W-1:0]  position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          done,
  output logic             [STAT_W-1:0] status,
  output logic             [FOUND_W-1:0] found_position,
  output logic signed      [DATA_W-1:0] read_data,
  output logic             [FILL_W-1:0] fill_count
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int PW     = (CW > POS_W) ? CW : POS_W;
  localparam int IW     = $clog2(CAPACITY);
  localparam int LEVELS = IW;
  localparam int TW     = $clog2(LEVELS + 1);

  state_t            state, state_next;
  logic [TW-1:0]     wcnt, wcnt_next;
  logic [CW-1:0]     count, count_next;
  logic [2:0]        req_op;
  logic [POS_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_value;

  logic              res_load;
  logic [STAT_W-1:0] res_status;
  logic [IW-1:0]     res_found;
  logic [DATA_W-1:0] res_data;

  cmd_t              cmd;
  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  logic              ins_ok;
  logic              idx_ok;
  logic              full;

  logic [DATA_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] hit;
  logic              root_hit;
  logic [IW-1:0]     root_idx;
  logic [DATA_W-1:0] root_data;

  assign pos_w  = PW'(req_pos);
  assign cnt_w  = PW'(count);
  assign full   = count == CW'(CAPACITY);
  assign ins_ok = (pos_w <= cnt_w) && !full;
  assign idx_ok = pos_w < cnt_w;
  assign busy   = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wcnt  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      wcnt  <= wcnt_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    wcnt_next  = wcnt;
    count_next = count;
    res_load   = 1'b0;
    res_status = ST_BAD;
    res_found  = '0;
    res_data   = '0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        res_load   = 1'b1;
        unique case (op_t'(req_op))
          OP_INSERT: begin
            if (ins_ok) begin
              cmd.ins    = 1'b1;
              count_next = count + 1'b1;
              res_status = ST_DONE;
            end
          end
          OP_DELETE: begin
            if (idx_ok) begin
              cmd.del    = 1'b1;
              count_next = count - 1'b1;
              res_status = ST_DONE;
            end
          end
          OP_UPDATE: begin
            if (idx_ok) begin
              cmd.upd    = 1'b1;
              res_status = ST_DONE;
            end
          end
          OP_SEARCH: begin
            cmd.srch   = 1'b1;
            res_load   = 1'b0;
            state_next = S_WAIT;
            wcnt_next  = TW'(1);
          end
          OP_READ: begin
            if (idx_ok) begin
              cmd.rd     = 1'b1;
              res_load   = 1'b0;
              state_next = S_WAIT;
              wcnt_next  = TW'(1);
            end
          end
          default: begin
            res_status = ST_BAD;
          end
        endcase
      end
      S_WAIT: begin
        cmd.srch = op_t'(req_op) == OP_SEARCH;
        cmd.rd   = op_t'(req_op) == OP_READ;
        if (wcnt == TW'(LEVELS)) begin
          state_next = S_IDLE;
          res_load   = 1'b1;
          if (cmd.rd) begin
            res_status = ST_DONE;
            res_data   = root_data;
          end else if (root_hit) begin
            res_status = ST_DONE;
            res_found  = root_idx;
          end else begin
            res_status = ST_MISS;
          end
        end else begin
          wcnt_next = wcnt + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_op    <= op;
      req_pos   <= position;
      req_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status         <= res_status;
      found_position <= FOUND_W'(res_found);
      read_data      <= res_data;
      fill_count     <= FILL_W'(count_next);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = entry[0];
    end else begin : g_mid_l
      assign left_in = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = entry[g];
    end else begin : g_mid_r
      assign right_in = entry[g+1];
    end
    isa_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (pos_w),
      .count (cnt_w),
      .value (req_value),
      .left  (left_in),
      .right (right_in),
      .entry (entry[g]),
      .hit   (hit[g])
    );
  end

  isa_find_tree #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_tree (
    .clk       (clk),
    .leaf_hit  (hit),
    .leaf_data (entry),
    .root_hit  (root_hit),
    .root_idx  (root_idx),
    .root_data (root_data)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a transaction in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the fill count");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_MISS) |-> found_position == '0)
    else $error("miss with nonzero position");

  a_one_cycle_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire
